// ===== rtl/eeg_packet_parser_forwarder_assert.svh =====
// Assertion macros shared by the queue and forwarder modules.
`ifndef EEG_PACKET_PARSER_FORWARDER_ASSERT_SVH
`define EEG_PACKET_PARSER_FORWARDER_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define EPP_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error("condition violated");

// The consequent must hold in the same cycle as the antecedent.
`define EPP_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication violated");

// The consequent must hold in the cycle after the antecedent.
`define EPP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== rtl/epp_pkg.sv =====
// Package with the types and constants of the EEG packet parser and forwarder.
package epp_pkg;

  localparam logic [7:0] MAX_PAYLOAD = 8'd252;
  localparam logic [7:0] SYNC_BYTE   = 8'hAA;
  localparam logic [7:0] FRAME_HEAD  = 8'hBB;
  localparam logic [7:0] FRAME_TAIL  = 8'hEE;
  localparam logic [7:0] CODE_EXT    = 8'h80;
  localparam logic [7:0] CODE_SIGNAL = 8'h02;
  localparam logic [7:0] CODE_ATTN   = 8'h04;
  localparam logic [7:0] CODE_MEDIT  = 8'h05;
  localparam logic [7:0] FATIGUE_TOP = 8'd100;
  localparam logic [7:0] SIGNAL_INIT = 8'd200;

  // Frame command queue depth (power of two).
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Index of the closing byte of a frame.
  localparam logic [2:0] LAST_IDX = 3'd4;

  typedef enum logic [2:0] {
    PH_HUNT_FIRST  = 3'd0,
    PH_HUNT_SECOND = 3'd1,
    PH_LENGTH      = 3'd2,
    PH_PAYLOAD     = 3'd3,
    PH_CHECK       = 3'd4
  } frame_phase_t;

  typedef enum logic [1:0] {
    RP_CODE  = 2'd0,
    RP_VALUE = 2'd1,
    RP_LEN   = 2'd2,
    RP_SKIP  = 2'd3
  } rec_phase_t;

  // One committed frame waiting to be sent.
  typedef struct packed {
    logic [7:0] attention;
    logic [7:0] fatigue;
    logic [7:0] signal;
  } frame_cmd_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/epp_parser.sv =====
// Front end: sync hunt, length, record walk and checksum; queues committed frames.
module epp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_take,
  input  logic [7:0]          rx_byte,
  output logic                push,
  output epp_pkg::frame_cmd_t push_cmd
);

  epp_pkg::frame_phase_t phase_r, phase_nxt;
  epp_pkg::rec_phase_t   rphase_r, rphase_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] code_r, code_nxt;
  logic [7:0] skip_r, skip_nxt;
  logic [7:0] pend_sig_r, pend_sig_nxt;
  logic [7:0] pend_att_r, pend_att_nxt;
  logic [7:0] pend_med_r, pend_med_nxt;
  logic       pend_chg_r, pend_chg_nxt;
  logic [7:0] held_sig_r, held_sig_nxt;
  logic [7:0] held_att_r, held_att_nxt;
  logic [7:0] held_med_r, held_med_nxt;
  logic       good;

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= epp_pkg::PH_HUNT_FIRST;
      rphase_r   <= epp_pkg::RP_CODE;
      len_r      <= '0;
      cnt_r      <= '0;
      sum_r      <= '0;
      code_r     <= '0;
      skip_r     <= '0;
      pend_sig_r <= epp_pkg::SIGNAL_INIT;
      pend_att_r <= '0;
      pend_med_r <= '0;
      pend_chg_r <= 1'b0;
      held_sig_r <= epp_pkg::SIGNAL_INIT;
      held_att_r <= '0;
      held_med_r <= '0;
    end else begin
      phase_r    <= phase_nxt;
      rphase_r   <= rphase_nxt;
      len_r      <= len_nxt;
      cnt_r      <= cnt_nxt;
      sum_r      <= sum_nxt;
      code_r     <= code_nxt;
      skip_r     <= skip_nxt;
      pend_sig_r <= pend_sig_nxt;
      pend_att_r <= pend_att_nxt;
      pend_med_r <= pend_med_nxt;
      pend_chg_r <= pend_chg_nxt;
      held_sig_r <= held_sig_nxt;
      held_att_r <= held_att_nxt;
      held_med_r <= held_med_nxt;
    end
  end

  // Needs a known value record and a checksum equal to the inverted low sum byte.
  assign good = ((~sum_r) == rx_byte) && pend_chg_r;

  // Frame command built from the pending values.
  always_comb begin
    push_cmd.attention = pend_att_r;
    push_cmd.signal    = pend_sig_r;
    push_cmd.fatigue   = (pend_med_r >= epp_pkg::FATIGUE_TOP) ? 8'd0
                       : (epp_pkg::FATIGUE_TOP - pend_med_r);
  end

  // Next state for each accepted word.
  always_comb begin
    phase_nxt    = phase_r;
    rphase_nxt   = rphase_r;
    len_nxt      = len_r;
    cnt_nxt      = cnt_r;
    sum_nxt      = sum_r;
    code_nxt     = code_r;
    skip_nxt     = skip_r;
    pend_sig_nxt = pend_sig_r;
    pend_att_nxt = pend_att_r;
    pend_med_nxt = pend_med_r;
    pend_chg_nxt = pend_chg_r;
    held_sig_nxt = held_sig_r;
    held_att_nxt = held_att_r;
    held_med_nxt = held_med_r;
    push         = 1'b0;
    if (byte_take) begin
      unique case (phase_r)
        epp_pkg::PH_HUNT_SECOND: begin
          phase_nxt = (rx_byte == epp_pkg::SYNC_BYTE) ? epp_pkg::PH_LENGTH
                                                      : epp_pkg::PH_HUNT_FIRST;
        end
        epp_pkg::PH_LENGTH: begin
          if (rx_byte > epp_pkg::MAX_PAYLOAD) begin
            phase_nxt = epp_pkg::PH_HUNT_FIRST;
          end else begin
            len_nxt      = rx_byte;
            cnt_nxt      = '0;
            sum_nxt      = '0;
            rphase_nxt   = epp_pkg::RP_CODE;
            code_nxt     = '0;
            skip_nxt     = '0;
            pend_sig_nxt = held_sig_r;
            pend_att_nxt = held_att_r;
            pend_med_nxt = held_med_r;
            pend_chg_nxt = 1'b0;
            phase_nxt    = (rx_byte == 8'd0) ? epp_pkg::PH_CHECK : epp_pkg::PH_PAYLOAD;
          end
        end
        epp_pkg::PH_PAYLOAD: begin
          sum_nxt = sum_r + rx_byte;
          cnt_nxt = cnt_r + 8'd1;
          if (cnt_nxt >= len_r) begin
            phase_nxt = epp_pkg::PH_CHECK;
          end
          // Walk the type-length-value records.
          unique case (rphase_r)
            epp_pkg::RP_CODE: begin
              code_nxt   = rx_byte;
              rphase_nxt = (rx_byte >= epp_pkg::CODE_EXT) ? epp_pkg::RP_LEN
                                                          : epp_pkg::RP_VALUE;
            end
            epp_pkg::RP_VALUE: begin
              if (code_r == epp_pkg::CODE_SIGNAL) begin
                pend_sig_nxt = rx_byte;
                pend_chg_nxt = 1'b1;
              end else if (code_r == epp_pkg::CODE_ATTN) begin
                pend_att_nxt = rx_byte;
                pend_chg_nxt = 1'b1;
              end else if (code_r == epp_pkg::CODE_MEDIT) begin
                pend_med_nxt = rx_byte;
                pend_chg_nxt = 1'b1;
              end
              rphase_nxt = epp_pkg::RP_CODE;
            end
            epp_pkg::RP_LEN: begin
              skip_nxt   = rx_byte;
              rphase_nxt = (rx_byte == 8'd0) ? epp_pkg::RP_CODE : epp_pkg::RP_SKIP;
            end
            epp_pkg::RP_SKIP: begin
              skip_nxt = skip_r - 8'd1;
              if (skip_nxt == 8'd0) begin
                rphase_nxt = epp_pkg::RP_CODE;
              end
            end
          endcase
        end
        epp_pkg::PH_CHECK: begin
          if (good) begin
            held_sig_nxt = pend_sig_r;
            held_att_nxt = pend_att_r;
            held_med_nxt = pend_med_r;
            push         = 1'b1;
          end
          pend_chg_nxt = 1'b0;
          phase_nxt    = epp_pkg::PH_HUNT_FIRST;
        end
        default: begin
          phase_nxt = (rx_byte == epp_pkg::SYNC_BYTE) ? epp_pkg::PH_HUNT_SECOND
                                                      : epp_pkg::PH_HUNT_FIRST;
        end
      endcase
    end
  end

endmodule

// ===== rtl/epp_queue.sv =====
// Short queue of committed frame commands between parser and forwarder.
`include "eeg_packet_parser_forwarder_assert.svh"

module epp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  epp_pkg::frame_cmd_t push_cmd,
  input  logic                pop,
  output epp_pkg::frame_cmd_t head_cmd,
  output epp_pkg::q_stat_t    stat
);

  epp_pkg::frame_cmd_t slot_r [epp_pkg::QDEPTH];
  logic [epp_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [epp_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [epp_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Slot storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign head_cmd   = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == epp_pkg::QCNT_W'(epp_pkg::QDEPTH));
  assign stat.empty = (cnt_r == '0);

  `EPP_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= epp_pkg::QCNT_W'(epp_pkg::QDEPTH))
  `EPP_ASSERT_IMPLY(a_no_overflow, clk, rst_n, push, !stat.full)
  `EPP_ASSERT_IMPLY(a_no_underflow, clk, rst_n, pop, !stat.empty)

endmodule

// ===== rtl/epp_forwarder.sv =====
// Back end: sends each queued command as the five-word frame BB att fatigue sig EE.
`include "eeg_packet_parser_forwarder_assert.svh"

module epp_forwarder (
  input  logic                clk,
  input  logic                rst_n,
  input  epp_pkg::frame_cmd_t head_cmd,
  input  epp_pkg::q_stat_t    stat,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_frame_last
);

  epp_pkg::frame_cmd_t cmd_r, cmd_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       busy_r, busy_nxt;
  logic       out_take;

  assign out_take = out_valid && out_ready;

  // Load the next command when idle or as the closing word leaves.
  always_comb begin
    pop      = !stat.empty && (!busy_r || (out_take && idx_r == epp_pkg::LAST_IDX));
    cmd_nxt  = cmd_r;
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    if (pop) begin
      cmd_nxt  = head_cmd;
      idx_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (out_take) begin
      if (idx_r == epp_pkg::LAST_IDX) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
  end

  // Word select for the current frame position.
  always_comb begin
    unique case (idx_r)
      3'd0:    out_byte = epp_pkg::FRAME_HEAD;
      3'd1:    out_byte = cmd_r.attention;
      3'd2:    out_byte = cmd_r.fatigue;
      3'd3:    out_byte = cmd_r.signal;
      default: out_byte = epp_pkg::FRAME_TAIL;
    endcase
  end

  assign out_valid      = busy_r;
  assign out_frame_last = (idx_r == epp_pkg::LAST_IDX);

  `EPP_ASSERT_ALWAYS(a_idx_bound, clk, rst_n, idx_r <= epp_pkg::LAST_IDX)
  `EPP_ASSERT_IMPLY(a_last_is_tail, clk, rst_n, out_valid && out_frame_last,
                    out_byte == epp_pkg::FRAME_TAIL)
  `EPP_ASSERT_NEXT(a_head_follows, clk, rst_n, out_take && out_frame_last && !stat.empty,
                   out_valid && out_byte == epp_pkg::FRAME_HEAD)

endmodule

// ===== rtl/eeg_packet_parser_forwarder.sv =====
// A good frame is queued as its checksum word is taken and sent once the forwarder is free.
// One input word per cycle while the queue is not full; a frame leaves as five words.
// The parser stalls only when the two-entry frame queue is full.
// The forwarder sends one word per cycle while it holds a frame and out_ready is high.
// Reset (rst_n low, synchronous) clears the queue and returns to hunting for sync,
// with held signal 200 and attention and meditation 0.
module eeg_packet_parser_forwarder (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_frame_last
);

  epp_pkg::frame_cmd_t push_cmd;
  epp_pkg::frame_cmd_t head_cmd;
  epp_pkg::q_stat_t    stat;
  logic                push;
  logic                pop;

  // Input words are taken whenever a committed frame would have room.
  assign in_ready = !stat.full;

  epp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_take(in_valid && in_ready),
    .rx_byte  (in_rx_byte),
    .push     (push),
    .push_cmd (push_cmd)
  );

  epp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head_cmd(head_cmd),
    .stat    (stat)
  );

  epp_forwarder u_forwarder (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_cmd      (head_cmd),
    .stat          (stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_frame_last(out_frame_last)
  );

endmodule
